/* hw/rtl/dltc_pkg.sv */
// ----------------------------------------------------------------------------
// dltc_pkg
// Shared types and constants of the lexer token classifier: token classes,
// DFA state codes, result records and the reserved word table.
// ----------------------------------------------------------------------------
package dltc_pkg;

  localparam int unsigned MAX_LEXEME = 64;
  // The lexeme counter must hold MAX_LEXEME itself.
  localparam int unsigned CNT_W      = $clog2(MAX_LEXEME + 1);
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned TCLS_W     = 4;
  localparam int unsigned TLEN_W     = 7;

  localparam int unsigned KW_COUNT   = 9;
  localparam int unsigned KW_MAXLEN  = 9;

  // Words are right-aligned: the first character of a word of length L sits
  // at bits [8*L-1 -: 8].
  localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_COUNT] = '{
    72'("se"), 72'("senao"), 72'("inicio"), 72'("fim"), 72'("enquanto"),
    72'("principal"), 72'("inteiro"), 72'("real"), 72'("literal")
  };
  localparam int unsigned KW_LEN [KW_COUNT] = '{2, 5, 6, 3, 8, 9, 7, 4, 7};

  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  typedef enum logic [TCLS_W-1:0] {
    TC_IDENT    = 4'd0,
    TC_RESERVED = 4'd1,
    TC_REL      = 4'd2,
    TC_ARITH    = 4'd3,
    TC_PUNCT    = 4'd4,
    TC_DELIM    = 4'd5,
    TC_STRING   = 4'd6,
    TC_ASSIGN   = 4'd7,
    TC_INT      = 4'd8,
    TC_REAL     = 4'd9,
    TC_LOGICAL  = 4'd10,
    TC_EQUALS   = 4'd11,
    TC_LINE_END = 4'd12
  } token_class_e;

  typedef enum logic [29:0] {
    S_REJECT      = 30'h0000_0001,
    S_START       = 30'h0000_0002,
    S_IDENT       = 30'h0000_0004,
    S_INT         = 30'h0000_0008,
    S_DOT         = 30'h0000_0010,
    S_STR         = 30'h0000_0020,
    S_LT          = 30'h0000_0040,
    S_GT          = 30'h0000_0080,
    S_BANG        = 30'h0000_0100,
    S_ARITH       = 30'h0000_0200,
    S_PUNCT       = 30'h0000_0400,
    S_DELIM       = 30'h0000_0800,
    S_INT_DOT     = 30'h0000_1000,
    S_DOT_E       = 30'h0000_2000,
    S_DOT_O       = 30'h0000_4000,
    S_DOT_N       = 30'h0000_8000,
    S_STR_QUOTE   = 30'h0001_0000,
    S_LE          = 30'h0002_0000,
    S_ASSIGN      = 30'h0004_0000,
    S_GE          = 30'h0008_0000,
    S_NE          = 30'h0010_0000,
    S_REAL        = 30'h0020_0000,
    S_AND         = 30'h0040_0000,
    S_DOT_NA      = 30'h0080_0000,
    S_DOT_OU      = 30'h0100_0000,
    S_OR          = 30'h0200_0000,
    S_DOT_NAO     = 30'h0400_0000,
    S_NOT         = 30'h0800_0000,
    S_EQ          = 30'h1000_0000,
    S_LINE_END    = 30'h2000_0000
  } dfa_state_e;

  typedef struct packed {
    logic         acc;
    token_class_e cls;
  } class_t;

  typedef struct packed {
    token_class_e      cls;
    logic [TLEN_W-1:0] len;
    logic              err;
  } result_t;

  // What one character leaves behind: one or two results.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

endpackage

/* hw/rtl/dltc_front.sv */
// ----------------------------------------------------------------------------
// dltc_front
// DFA front end: takes one character per cycle while accept_i is high, advances
// the maximal-munch automaton and the reserved word flags, and writes the
// results of a character, if it has any, as one queue entry.
// ----------------------------------------------------------------------------
module dltc_front import dltc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_data_i,
  output logic              wr_valid_o,
  output entry_t            wr_entry_o
);

  function automatic logic is_digit(logic [CHAR_W-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(logic [CHAR_W-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic dfa_state_e next_state(dfa_state_e s, logic [CHAR_W-1:0] c);
    dfa_state_e n;
    n = S_REJECT;
    unique case (s) inside
      S_START: begin
        if (is_letter(c)) n = S_IDENT;
        else if (is_digit(c)) n = S_INT;
        else if (c == "," || c == ";") n = S_PUNCT;
        else if (c == "{" || c == "}" || c == "(" || c == ")" || c == "[" || c == "]")
          n = S_DELIM;
        else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "%") n = S_ARITH;
        else if (c == ".") n = S_DOT;
        else if (c == 8'h22) n = S_STR;
        else if (c == "<") n = S_LT;
        else if (c == ">") n = S_GT;
        else if (c == "!") n = S_BANG;
        else if (c == "=") n = S_EQ;
        else if (c == CH_LF || c == CH_NUL) n = S_LINE_END;
      end
      S_IDENT:   if (is_letter(c) || is_digit(c)) n = S_IDENT;
      S_INT: begin
        if (is_digit(c)) n = S_INT;
        else if (c == ".") n = S_INT_DOT;
      end
      S_DOT: begin
        if (c == "e") n = S_DOT_E;
        else if (c == "o") n = S_DOT_O;
        else if (c == "n") n = S_DOT_N;
      end
      S_STR, S_STR_QUOTE: begin
        // A closing quote may be followed by more string text.
        if (c == 8'h22) n = (s == S_STR) ? S_STR_QUOTE : S_STR;
        else if (c != CH_LF && c != CH_NUL) n = S_STR;
      end
      S_LT: begin
        if (c == "=") n = S_LE;
        else if (c == "-") n = S_ASSIGN;
      end
      S_GT:        if (c == "=") n = S_GE;
      S_BANG:      if (c == "=") n = S_NE;
      S_INT_DOT:   if (is_digit(c)) n = S_REAL;
      S_DOT_E:     if (c == ".") n = S_AND;
      S_DOT_O:     if (c == "u") n = S_DOT_OU;
      S_DOT_N:     if (c == "a") n = S_DOT_NA;
      S_REAL:      if (is_digit(c)) n = S_REAL;
      S_DOT_NA:    if (c == "o") n = S_DOT_NAO;
      S_DOT_OU:    if (c == ".") n = S_OR;
      S_DOT_NAO:   if (c == ".") n = S_NOT;
      default:     n = S_REJECT;
    endcase
    return n;
  endfunction

  // Class of the states that accept anything but identifiers.
  function automatic class_t class_of(dfa_state_e s);
    class_t r;
    r = '{acc: 1'b1, cls: TC_IDENT};
    unique case (s) inside
      S_LT, S_GT, S_LE, S_GE, S_NE: r.cls = TC_REL;
      S_ARITH:                      r.cls = TC_ARITH;
      S_DOT, S_PUNCT:               r.cls = TC_PUNCT;
      S_DELIM:                      r.cls = TC_DELIM;
      S_STR_QUOTE:                  r.cls = TC_STRING;
      S_ASSIGN:                     r.cls = TC_ASSIGN;
      S_INT:                        r.cls = TC_INT;
      S_REAL:                       r.cls = TC_REAL;
      S_AND, S_OR, S_NOT:           r.cls = TC_LOGICAL;
      S_EQ:                         r.cls = TC_EQUALS;
      S_LINE_END:                   r.cls = TC_LINE_END;
      default:                      r.acc = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_len(logic [CNT_W:0] n);
    return (n > (CNT_W+1)'(MAX_LEXEME)) ? CNT_W'(MAX_LEXEME) : n[CNT_W-1:0];
  endfunction

  dfa_state_e            state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [KW_COUNT-1:0]   cand_q, cand_d;
  logic                  halted_q, halted_d;
  logic                  resume_q;

  logic                  step;
  dfa_state_e            ns_first, ns;
  class_t                cur_class;
  logic                  reserved;
  logic                  redo;
  logic [CNT_W-1:0]      base_cnt;
  logic [KW_COUNT-1:0]   base_cand;
  logic [KW_COUNT-1:0]   kw_match;
  logic [CNT_W-1:0]      next_cnt;
  logic                  tail;
  result_t               tok_res, tail_res;

  assign step = accept_i && !halted_q && (char_code_i != CH_SPACE) && (char_code_i != CH_TAB);

  always_comb begin
    reserved = 1'b0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (cand_q[i] && (count_q == CNT_W'(KW_LEN[i]))) reserved = 1'b1;
    end
  end

  always_comb begin
    cur_class = class_of(state_q);
    if (state_q == S_IDENT) begin
      cur_class.acc = 1'b1;
      cur_class.cls = reserved ? TC_RESERVED : TC_IDENT;
    end
  end

  assign ns_first  = next_state(state_q, char_code_i);
  // The character cannot extend an accepted lexeme: emit it and start over.
  assign redo      = (ns_first == S_REJECT) && cur_class.acc;
  assign base_cnt  = redo ? '0 : count_q;
  assign base_cand = redo ? '1 : cand_q;
  assign ns        = redo ? next_state(S_START, char_code_i) : ns_first;
  assign next_cnt  = sat_len({1'b0, base_cnt} + 1'b1);
  assign tail      = (ns == S_REJECT) || (ns == S_LINE_END);

  // A word stays a candidate while its character at this position matches.
  always_comb begin
    int idx;
    kw_match = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      idx = 0;
      if (base_cnt < CNT_W'(KW_LEN[i])) begin
        idx = KW_LEN[i] - 1 - int'(base_cnt);
        kw_match[i] = (KW_TEXT[i][8*idx +: 8] == char_code_i);
      end
    end
  end

  always_comb begin
    tok_res.cls  = cur_class.cls;
    tok_res.len  = TLEN_W'(sat_len({1'b0, count_q}));
    tok_res.err  = 1'b0;
    tail_res.cls = (ns == S_REJECT) ? TC_IDENT : TC_LINE_END;
    tail_res.len = TLEN_W'(next_cnt);
    tail_res.err = (ns == S_REJECT);
  end

  always_comb begin
    wr_valid_o = step && (redo || tail);
    wr_entry_o.two = redo && tail;
    wr_entry_o.r0  = redo ? tok_res : tail_res;
    wr_entry_o.r1  = tail_res;
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    cand_d   = cand_q;
    halted_d = halted_q;
    if (step) begin
      if (tail) begin
        state_d = S_START;
        count_d = '0;
        cand_d  = '1;
        if ((ns == S_REJECT) && !resume_q) halted_d = 1'b1;
      end else begin
        state_d = ns;
        count_d = next_cnt;
        cand_d  = (ns == S_IDENT) ? (base_cand & kw_match) : base_cand;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_START;
      count_q  <= '0;
      cand_q   <= '1;
      halted_q <= 1'b0;
      resume_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cand_q   <= cand_d;
      halted_q <= halted_d;
      if (cfg_valid_i) resume_q <= cfg_data_i;
    end
  end

endmodule

/* hw/rtl/dltc_queue.sv */
// ----------------------------------------------------------------------------
// dltc_queue
// Short queue of per-character result entries between the DFA front end and
// the result back end.
// ----------------------------------------------------------------------------
module dltc_queue import dltc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_valid_i,
  input  entry_t wr_entry_i,
  input  logic   rd_pop_i,
  output logic   full_o,
  output logic   rd_valid_o,
  output entry_t rd_entry_o
);

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   fill_q;
  logic              do_wr, do_rd;

  assign full_o     = (fill_q == (QPTR_W+1)'(QDEPTH));
  assign rd_valid_o = (fill_q != '0);
  assign rd_entry_o = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_wr && !do_rd) fill_q <= fill_q + 1'b1;
      else if (do_rd && !do_wr) fill_q <= fill_q - 1'b1;
    end
  end

endmodule

/* hw/rtl/dltc_back.sv */
// ----------------------------------------------------------------------------
// dltc_back
// Result back end: holds one queue entry in an output register and hands out
// its one or two results in order, marking the last one of each character.
// ----------------------------------------------------------------------------
module dltc_back import dltc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_valid_i,
  input  entry_t            rd_entry_i,
  output logic              rd_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [TCLS_W-1:0] token_class_o,
  output logic [TLEN_W-1:0] token_length_o,
  output logic              is_error_o,
  output logic              last_o
);

  entry_t  entry_q;
  logic    valid_q;
  logic    sel_q;
  logic    take, cur_final;
  result_t res;

  assign take      = valid_q && pop_i;
  assign cur_final = !entry_q.two || sel_q;
  assign rd_pop_o  = rd_valid_i && (!valid_q || (take && cur_final));

  assign res            = sel_q ? entry_q.r1 : entry_q.r0;
  assign empty_o        = !valid_q;
  assign token_class_o  = res.cls;
  assign token_length_o = res.len;
  assign is_error_o     = res.err;
  assign last_o         = cur_final;

  always_ff @(posedge clk_i) begin
    if (rd_pop_o) entry_q <= rd_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (rd_pop_o) begin
      valid_q <= 1'b1;
      sel_q   <= 1'b0;
    end else if (take) begin
      if (cur_final) valid_q <= 1'b0;
      else sel_q <= 1'b1;
    end
  end

endmodule

/* hw/rtl/dfa_lexer_token_classifier.sv */
// ----------------------------------------------------------------------------
// dfa_lexer_token_classifier
// Throughput: one character per cycle while full is low; a character with two
// results holds the result port for both in turn, absorbed by a four-entry queue.
// A result passes through the queue and the back end's output register before
// it reaches the result ports. Reset is asynchronous, active low; it restarts the
// DFA and clears halt and resume.
// ----------------------------------------------------------------------------
module dfa_lexer_token_classifier import dltc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic              pop,
  output logic              empty,
  output logic [TCLS_W-1:0] token_class_o,
  output logic [TLEN_W-1:0] token_length_o,
  output logic              is_error_o,
  output logic              last_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i
);

  logic   accept;
  logic   wr_valid;
  entry_t wr_entry;
  logic   rd_valid;
  entry_t rd_entry;
  logic   rd_pop;

  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  dltc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (char_code_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .wr_valid_o  (wr_valid),
    .wr_entry_o  (wr_entry)
  );

  dltc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_entry_i (wr_entry),
    .rd_pop_i   (rd_pop),
    .full_o     (full),
    .rd_valid_o (rd_valid),
    .rd_entry_o (rd_entry)
  );

  dltc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rd_valid_i     (rd_valid),
    .rd_entry_i     (rd_entry),
    .rd_pop_o       (rd_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .token_class_o  (token_class_o),
    .token_length_o (token_length_o),
    .is_error_o     (is_error_o),
    .last_o         (last_o)
  );

endmodule

/* tb/tb_dfa_lexer_token_classifier.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dfa_lexer_token_classifier
// Feeds character streams into the lexer and checks every token against a
// behavioral DFA in this bench or typed tokens. A short directed table comes
// first, then phases of random lexemes under different push and pop idling.
// The run ends with resume cleared, so the first error halts it for good.
// ----------------------------------------------------------------------------
module tb_dfa_lexer_token_classifier;
  import dltc_pkg::*;

  typedef struct packed {
    token_class_e      cls;
    logic [TLEN_W-1:0] len;
    logic              err;
    logic              last;
  } token_t;

  // A directed row either carries its tokens typed in or leaves them to the
  // behavioral DFA (typed = 0).
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              typed;
    logic [1:0]        cnt;
    token_t            t0;
    token_t            t1;
  } stim_row_t;

  localparam token_t NO_TOKEN      = '0;
  localparam int     SETTLE_CYCLES = 12;
  localparam int     PHASE_CHARS   = 360;
  localparam int     DIR_ROWS      = 29;
  localparam int     SEND_IDLE [4] = '{0, 64, 0, 24};
  localparam int     RECV_STALL [4] = '{0, 0, 64, 24};

  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{CH_LF,  1'b1, 2'd1, '{TC_LINE_END, 7'd1, 1'b0, 1'b1}, NO_TOKEN},
    '{CH_NUL, 1'b1, 2'd1, '{TC_LINE_END, 7'd1, 1'b0, 1'b1}, NO_TOKEN},
    '{8'hFF,  1'b1, 2'd1, '{TC_IDENT, 7'd1, 1'b1, 1'b1}, NO_TOKEN},
    '{"s",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"e",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CH_SPACE, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"(",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CH_TAB, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"<",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"-",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"4",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{".",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"7",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{",",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"\"",   1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"\"",   1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"q",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"\"",   1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CH_LF,  1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"=",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"a",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"+",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{".",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"e",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{".",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"7",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"#",    1'b1, 2'd2, '{TC_INT, 7'd1, 1'b0, 1'b0}, '{TC_IDENT, 7'd1, 1'b1, 1'b1}},
    '{">",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{"=",    1'b0, 2'd0, NO_TOKEN, NO_TOKEN}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [CHAR_W-1:0] char_code_i;
  logic              pop;
  logic              empty;
  logic [TCLS_W-1:0] token_class_o;
  logic [TLEN_W-1:0] token_length_o;
  logic              is_error_o;
  logic              last_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic              cfg_data_i;

  // Behavioral lexer state.
  dfa_state_e          lx_state;
  int unsigned         lx_count;
  logic [KW_COUNT-1:0] kw_live;
  bit                  lx_halted;
  bit                  resume_on;

  token_t pending_tokens [$];
  int     mismatch_cnt;
  int     chars_sent;
  int     send_idle_pct;
  int     stall_pct;

  string rel_ops [7]   = '{"<", "<=", "<-", ">", ">=", "!=", "="};
  string logic_ops [3] = '{".e.", ".ou.", ".nao."};
  string broken [8]    = '{".", ".n", ".na", ".o", "!", "9.", "<", "\"ab"};
  string singles       = ",;{}()[]+-*/%.";

  dfa_lexer_token_classifier u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .char_code_i    (char_code_i),
    .pop            (pop),
    .empty          (empty),
    .token_class_o  (token_class_o),
    .token_length_o (token_length_o),
    .is_error_o     (is_error_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic dfa_state_e next_dfa(dfa_state_e s, logic [7:0] c);
    logic       alpha;
    logic       num;
    dfa_state_e ns;
    alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    num   = c >= "0" && c <= "9";
    ns    = S_REJECT;
    case (s)
      S_START: begin
        if (alpha) ns = S_IDENT;
        else if (num) ns = S_INT;
        else if (c == "," || c == ";") ns = S_PUNCT;
        else if (c == "{" || c == "}" || c == "(" || c == ")" || c == "[" || c == "]")
          ns = S_DELIM;
        else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "%") ns = S_ARITH;
        else if (c == ".") ns = S_DOT;
        else if (c == "\"") ns = S_STR;
        else if (c == "<") ns = S_LT;
        else if (c == ">") ns = S_GT;
        else if (c == "!") ns = S_BANG;
        else if (c == "=") ns = S_EQ;
        else if (c == CH_LF || c == CH_NUL) ns = S_LINE_END;
      end
      S_IDENT:   if (alpha || num) ns = S_IDENT;
      S_INT: begin
        if (num) ns = S_INT;
        else if (c == ".") ns = S_INT_DOT;
      end
      S_DOT: begin
        if (c == "e") ns = S_DOT_E;
        else if (c == "o") ns = S_DOT_O;
        else if (c == "n") ns = S_DOT_N;
      end
      // A quote after a closed string reopens it; anything but a line end
      // continues it.
      S_STR, S_STR_QUOTE: begin
        if (c == "\"") ns = (s == S_STR) ? S_STR_QUOTE : S_STR;
        else if (c != CH_LF && c != CH_NUL) ns = S_STR;
      end
      S_LT: begin
        if (c == "=") ns = S_LE;
        else if (c == "-") ns = S_ASSIGN;
      end
      S_GT:      if (c == "=") ns = S_GE;
      S_BANG:    if (c == "=") ns = S_NE;
      S_INT_DOT: if (num) ns = S_REAL;
      S_REAL:    if (num) ns = S_REAL;
      S_DOT_E:   if (c == ".") ns = S_AND;
      S_DOT_O:   if (c == "u") ns = S_DOT_OU;
      S_DOT_N:   if (c == "a") ns = S_DOT_NA;
      S_DOT_NA:  if (c == "o") ns = S_DOT_NAO;
      S_DOT_OU:  if (c == ".") ns = S_OR;
      S_DOT_NAO: if (c == ".") ns = S_NOT;
      default:   ns = S_REJECT;
    endcase
    return ns;
  endfunction

  function automatic class_t accept_class(dfa_state_e s);
    class_t r;
    r.acc = 1'b1;
    r.cls = TC_IDENT;
    case (s)
      S_IDENT: begin
        for (int i = 0; i < KW_COUNT; i++)
          if (kw_live[i] && KW_LEN[i] == lx_count) r.cls = TC_RESERVED;
      end
      S_LT, S_GT, S_LE, S_GE, S_NE: r.cls = TC_REL;
      S_ARITH:                     r.cls = TC_ARITH;
      S_DOT, S_PUNCT:              r.cls = TC_PUNCT;
      S_DELIM:                     r.cls = TC_DELIM;
      S_STR_QUOTE:                 r.cls = TC_STRING;
      S_ASSIGN:                    r.cls = TC_ASSIGN;
      S_INT:                       r.cls = TC_INT;
      S_REAL:                      r.cls = TC_REAL;
      S_AND, S_OR, S_NOT:          r.cls = TC_LOGICAL;
      S_EQ:                        r.cls = TC_EQUALS;
      default:                     r.acc = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [TLEN_W-1:0] clip_len(int unsigned n);
    return TLEN_W'((n > MAX_LEXEME) ? MAX_LEXEME : n);
  endfunction

  task automatic restart_lexeme();
    lx_state = S_START;
    lx_count = 0;
    kw_live  = '1;
  endtask

  // Advances the behavioral DFA by one character and returns its tokens.
  task automatic lex_char(input logic [7:0] c, output token_t r0, output token_t r1,
                          output int n);
    token_t     r [2];
    dfa_state_e ns;
    class_t     ac;
    int         i;
    r[0] = NO_TOKEN;
    r[1] = NO_TOKEN;
    n    = 0;
    if (!lx_halted && c != CH_SPACE && c != CH_TAB) begin
      ns = next_dfa(lx_state, c);
      if (ns == S_REJECT) begin
        ac = accept_class(lx_state);
        if (ac.acc) begin
          r[n] = '{ac.cls, clip_len(lx_count), 1'b0, 1'b0};
          n++;
          restart_lexeme();
          ns = next_dfa(S_START, c);
        end
      end
      if (ns == S_REJECT) begin
        r[n] = '{TC_IDENT, clip_len(lx_count + 1), 1'b1, 1'b0};
        n++;
        restart_lexeme();
        if (!resume_on) lx_halted = 1'b1;
      end else if (ns == S_LINE_END) begin
        r[n] = '{TC_LINE_END, clip_len(lx_count + 1), 1'b0, 1'b0};
        n++;
        restart_lexeme();
      end else begin
        if (ns == S_IDENT) begin
          for (i = 0; i < KW_COUNT; i++) begin
            if (lx_count >= KW_LEN[i]) kw_live[i] = 1'b0;
            else if (KW_TEXT[i][8*(KW_LEN[i]-lx_count)-1 -: 8] != c) kw_live[i] = 1'b0;
          end
        end
        lx_state = ns;
        lx_count = clip_len(lx_count + 1);
      end
      if (n > 0) r[n-1].last = 1'b1;
    end
    r0 = r[0];
    r1 = r[1];
  endtask

  task automatic note_mismatch(input string what);
    mismatch_cnt++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Called at a rising edge; returns at the edge where the character is taken.
  task automatic send_char(input stim_row_t row);
    token_t p0;
    token_t p1;
    int     pn;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    char_code_i <= row.ch;
    @(negedge clk_i);
    while (full) @(negedge clk_i);
    lex_char(row.ch, p0, p1, pn);
    if (row.typed) begin
      pn = row.cnt;
      p0 = row.t0;
      p1 = row.t1;
    end
    if (pn > 0) pending_tokens.push_back(p0);
    if (pn > 1) pending_tokens.push_back(p1);
    if (row.ch != CH_SPACE && row.ch != CH_TAB) chars_sent++;
    @(posedge clk_i);
  endtask

  task automatic feed(input logic [7:0] c);
    send_char('{c, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN});
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) feed(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] ch;
    ch = 8'("a" + $urandom_range(25));
    if ($urandom_range(3) == 0) ch = ch ^ 8'h20;
    return ch;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  // Mostly well-formed lexemes with random content, some noise and some
  // lexemes cut short.
  task automatic feed_lexeme();
    int         k;
    int         len;
    int         i;
    int         w;
    int         flip;
    logic [7:0] ch;
    k = $urandom_range(99);
    if (k < 18) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(60, 75) : $urandom_range(1, 8);
      feed(rand_letter());
      for (i = 1; i < len; i++) feed(($urandom_range(3) == 0) ? rand_digit() : rand_letter());
    end else if (k < 34) begin
      // Reserved words, their prefixes, extensions and case variants.
      w = $urandom_range(KW_COUNT - 1);
      case ($urandom_range(3))
        0, 1:    len = KW_LEN[w];
        2:       len = $urandom_range(1, KW_LEN[w]);
        default: len = KW_LEN[w] + 1;
      endcase
      flip = ($urandom_range(7) == 0) ? $urandom_range(len - 1) : -1;
      for (i = 0; i < len; i++) begin
        if (i < KW_LEN[w]) ch = KW_TEXT[w][8*(KW_LEN[w]-i)-1 -: 8];
        else ch = rand_letter();
        if (i == flip) ch = ch ^ 8'h20;
        feed(ch);
      end
    end else if (k < 44) begin
      len = $urandom_range(1, 4);
      for (i = 0; i < len; i++) feed(rand_digit());
      if ($urandom_range(1) == 1) begin
        feed(".");
        len = $urandom_range(1, 3);
        for (i = 0; i < len; i++) feed(rand_digit());
      end
    end else if (k < 52) begin
      feed("\"");
      len = $urandom_range(0, 6);
      for (i = 0; i < len; i++) begin
        ch = 8'($urandom_range(1, 255));
        if (ch == CH_LF) ch = "x";
        feed(ch);
      end
      feed("\"");
      if ($urandom_range(3) == 0) begin
        feed(rand_letter());
        feed("\"");
      end
    end else if (k < 62) begin
      feed_text(rel_ops[$urandom_range(6)]);
    end else if (k < 68) begin
      feed_text(logic_ops[$urandom_range(2)]);
    end else if (k < 78) begin
      feed(singles[$urandom_range(singles.len() - 1)]);
    end else if (k < 84) begin
      feed(($urandom_range(1) == 1) ? CH_LF : CH_NUL);
    end else if (k < 92) begin
      feed(8'($urandom_range(255)));
    end else begin
      feed_text(broken[$urandom_range(7)]);
      feed(8'($urandom_range(255)));
    end
    if ($urandom_range(2) == 0) feed(($urandom_range(1) == 1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_resume(input bit v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    resume_on = v;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Outputs are sampled mid-cycle; a transaction completes at the next edge.
  always @(negedge clk_i) begin : token_check
    token_t want;
    if (rst_ni === 1'b1 && pop && !empty) begin
      if (pending_tokens.size() == 0) begin
        note_mismatch($sformatf("unexpected token class %0d length %0d",
                                token_class_o, token_length_o));
      end else begin
        want = pending_tokens.pop_front();
        if (token_class_o !== want.cls)
          note_mismatch($sformatf("token_class %0d, want %0d", token_class_o, want.cls));
        if (token_length_o !== want.len)
          note_mismatch($sformatf("token_length %0d, want %0d", token_length_o, want.len));
        if (is_error_o !== want.err)
          note_mismatch($sformatf("is_error %0b, want %0b", is_error_o, want.err));
        if (last_o !== want.last)
          note_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
      end
    end
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    push          <= 1'b0;
    char_code_i   <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= 1'b0;
    mismatch_cnt  = 0;
    chars_sent    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    resume_on     = 1'b0;
    lx_halted     = 1'b0;
    restart_lexeme();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_resume(1'b1);
    for (int i = 0; i < DIR_ROWS; i++) send_char(DIRECTED[i]);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      stall_pct     = RECV_STALL[ph];
      write_resume(1'b1);
      chars_sent = 0;
      while (chars_sent < PHASE_CHARS) feed_lexeme();
      settle();
    end

    // With resume cleared the first error halts the lexer; later characters
    // must produce nothing.
    write_resume(1'b0);
    while (!lx_halted) feed_lexeme();
    repeat (30) feed(8'($urandom_range(255)));
    settle();

    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
